>>> sv/tav_pkg.sv
package tav_pkg;

    // Fixed widths of the result fields.
    localparam int AREA_W = 47;
    localparam int SIDE_W = 26;

    // Default coordinate width.
    localparam int COORD_WIDTH_DEF = 24;

    localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};
    localparam logic [SIDE_W-1:0] SIDE_MAX = {SIDE_W{1'b1}};

    // The three side lengths of one triangle, as they leave the block.
    typedef struct packed {
        logic [SIDE_W-1:0] ab;
        logic [SIDE_W-1:0] bc;
        logic [SIDE_W-1:0] ac;
    } t_sides;

endpackage

>>> sv/tav_if.sv
// Input channel: the three vertices of one triangle.
interface tav_in_if #(
    parameter int COORD_WIDTH = tav_pkg::COORD_WIDTH_DEF
);
    logic                   valid;
    logic                   ready;
    logic [COORD_WIDTH-1:0] ax;
    logic [COORD_WIDTH-1:0] ay;
    logic [COORD_WIDTH-1:0] az;
    logic [COORD_WIDTH-1:0] bx;
    logic [COORD_WIDTH-1:0] by_coord;
    logic [COORD_WIDTH-1:0] bz;
    logic [COORD_WIDTH-1:0] cx;
    logic [COORD_WIDTH-1:0] cy;
    logic [COORD_WIDTH-1:0] cz;

    modport source (
        output valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz,
        input  ready
    );
    modport sink (
        input  valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz,
        output ready
    );
endinterface

// Output channel: area and side lengths of one triangle.
interface tav_out_if;
    logic                        valid;
    logic                        ready;
    logic [tav_pkg::AREA_W-1:0]  area;
    logic [tav_pkg::SIDE_W-1:0]  side_ab;
    logic [tav_pkg::SIDE_W-1:0]  side_bc;
    logic [tav_pkg::SIDE_W-1:0]  side_ac;

    modport source (
        output valid, area, side_ab, side_bc, side_ac,
        input  ready
    );
    modport sink (
        input  valid, area, side_ab, side_bc, side_ac,
        output ready
    );
endinterface

>>> sv/triangle_area_from_vertices_core.sv
// Triangle area from three 3D vertices by Heron's formula in exact integer form.
// Coordinates are signed fixed point; each side is the floor square root of the
// squared distance, and area = floor(floor(sqrt(P)) / 4) with
// P = (L1+L2+L3)(-L1+L2+L3)(L1-L2+L3)(L1+L2-L3), zero for a degenerate triangle.
// The block is a single pipeline that takes one transaction every cycle while
// its output is not stalled; the depth is set by the two bit-per-stage square
// root units. When the output transaction is not taken the whole pipeline
// holds, and input ready drops until it is.
module triangle_area_from_vertices_core #(
    parameter int COORD_WIDTH = tav_pkg::COORD_WIDTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    tav_in_if.sink   i_in,
    tav_out_if.source o_out
);
    localparam int CW    = COORD_WIDTH;
    localparam int DW    = CW + 1;          // coordinate difference
    localparam int SQW   = 2 * CW + 1;      // squared difference
    localparam int SUMW  = 2 * CW + 4;      // sum of three squares, even
    localparam int LW    = SUMW / 2;        // side length
    localparam int FW    = LW + 2;          // one Heron factor
    localparam int PW    = 4 * FW;          // product of all factors
    localparam int RW    = PW / 2;          // root of the product
    localparam int QW    = RW - 2;          // root divided by four
    localparam int LCW   = (LW > tav_pkg::SIDE_W) ? LW : tav_pkg::SIDE_W;
    localparam int ACW   = (QW > tav_pkg::AREA_W) ? QW : tav_pkg::AREA_W;
    localparam int TOTAL = 9 + LW + RW;
    localparam int SDLY  = 6 + RW;

    logic en;
    logic [TOTAL-1:0] r_vld;

    // Whole pipeline advances unless a finished result is waiting.
    assign en         = !r_vld[TOTAL-1] || o_out.ready;
    assign i_in.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[TOTAL-2:0], i_in.valid};
        end
    end

    // Stage 1: coordinate differences.
    logic signed [DW-1:0] r_d [9];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d[0] <= $signed({i_in.bx[CW-1], i_in.bx}) - $signed({i_in.ax[CW-1], i_in.ax});
            r_d[1] <= $signed({i_in.by_coord[CW-1], i_in.by_coord})
                    - $signed({i_in.ay[CW-1], i_in.ay});
            r_d[2] <= $signed({i_in.bz[CW-1], i_in.bz}) - $signed({i_in.az[CW-1], i_in.az});
            r_d[3] <= $signed({i_in.cx[CW-1], i_in.cx}) - $signed({i_in.bx[CW-1], i_in.bx});
            r_d[4] <= $signed({i_in.cy[CW-1], i_in.cy})
                    - $signed({i_in.by_coord[CW-1], i_in.by_coord});
            r_d[5] <= $signed({i_in.cz[CW-1], i_in.cz}) - $signed({i_in.bz[CW-1], i_in.bz});
            r_d[6] <= $signed({i_in.cx[CW-1], i_in.cx}) - $signed({i_in.ax[CW-1], i_in.ax});
            r_d[7] <= $signed({i_in.cy[CW-1], i_in.cy}) - $signed({i_in.ay[CW-1], i_in.ay});
            r_d[8] <= $signed({i_in.cz[CW-1], i_in.cz}) - $signed({i_in.az[CW-1], i_in.az});
        end
    end

    // Stage 2: squares, one multiplier per difference.
    logic [SQW-1:0] r_sq [9];
    for (genvar k = 0; k < 9; k++) begin : g_sq
        logic signed [2*DW-1:0] prod;
        assign prod = r_d[k] * r_d[k];
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq[k] <= prod[SQW-1:0];
            end
        end
    end

    // Stage 3: squared side lengths.
    logic [SUMW-1:0] r_ssum [3];
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int s = 0; s < 3; s++) begin
                r_ssum[s] <= SUMW'(r_sq[3*s]) + SUMW'(r_sq[3*s+1]) + SUMW'(r_sq[3*s+2]);
            end
        end
    end

    // Side length square roots.
    logic [LW-1:0] len [3];
    for (genvar s = 0; s < 3; s++) begin : g_side
        tav_isqrt #(.IN_W(SUMW)) u_side_sqrt (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_x    (r_ssum[s]),
            .o_root (len[s])
        );
    end

    // Stage 4: triangle check, Heron factors and saturated side outputs.
    logic [FW-1:0] l1, l2, l3;
    logic          tri_ok;
    logic [FW-1:0] n_f [4];
    logic [tav_pkg::SIDE_W-1:0] side_sat [3];
    logic [FW-1:0] r_f [4];
    tav_pkg::t_sides r_sdly [SDLY];

    always_comb begin
        l1 = FW'(len[0]);
        l2 = FW'(len[1]);
        l3 = FW'(len[2]);
        tri_ok = (l1 <= l2 + l3) && (l2 <= l1 + l3) && (l3 <= l1 + l2);
        n_f[0] = l1 + l2 + l3;
        n_f[1] = l2 + l3 - l1;
        n_f[2] = l1 + l3 - l2;
        n_f[3] = l1 + l2 - l3;
        if (!tri_ok) begin
            for (int k = 0; k < 4; k++) begin
                n_f[k] = '0;
            end
        end
        for (int s = 0; s < 3; s++) begin
            if (LCW'(len[s]) > LCW'(tav_pkg::SIDE_MAX)) begin
                side_sat[s] = tav_pkg::SIDE_MAX;
            end else begin
                side_sat[s] = tav_pkg::SIDE_W'(LCW'(len[s]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f        <= n_f;
            r_sdly[0]  <= '{ab: side_sat[0], bc: side_sat[1], ac: side_sat[2]};
            for (int k = 1; k < SDLY; k++) begin
                r_sdly[k] <= r_sdly[k-1];
            end
        end
    end

    // Stage 5: pairwise products of the factors.
    logic [2*FW-1:0] r_p1, r_p2;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1 <= (2*FW)'(r_f[0]) * (2*FW)'(r_f[1]);
            r_p2 <= (2*FW)'(r_f[2]) * (2*FW)'(r_f[3]);
        end
    end

    // Stage 6: partial products of the wide multiply, split at FW bits.
    logic [2*FW-1:0] r_ll, r_lh, r_hl, r_hh;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ll <= (2*FW)'(r_p1[FW-1:0])    * (2*FW)'(r_p2[FW-1:0]);
            r_lh <= (2*FW)'(r_p1[FW-1:0])    * (2*FW)'(r_p2[2*FW-1:FW]);
            r_hl <= (2*FW)'(r_p1[2*FW-1:FW]) * (2*FW)'(r_p2[FW-1:0]);
            r_hh <= (2*FW)'(r_p1[2*FW-1:FW]) * (2*FW)'(r_p2[2*FW-1:FW]);
        end
    end

    // Stage 7: middle terms combined.
    logic [2*FW:0]   r_mid;
    logic [2*FW-1:0] r_ll2, r_hh2;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mid <= (2*FW+1)'(r_lh) + (2*FW+1)'(r_hl);
            r_ll2 <= r_ll;
            r_hh2 <= r_hh;
        end
    end

    // Stage 8: full product, sixteen times the squared area.
    logic [PW-1:0] r_prod;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prod <= {r_hh2, r_ll2} + (PW'(r_mid) << FW);
        end
    end

    // Area square root.
    logic [RW-1:0] root_p;
    tav_isqrt #(.IN_W(PW)) u_area_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_x    (r_prod),
        .o_root (root_p)
    );

    // Output stage: divide by four and saturate.
    logic [QW-1:0]              quarter;
    logic [tav_pkg::AREA_W-1:0] n_area, r_area;
    always_comb begin
        quarter = root_p[RW-1:2];
        if (ACW'(quarter) > ACW'(tav_pkg::AREA_MAX)) begin
            n_area = tav_pkg::AREA_MAX;
        end else begin
            n_area = tav_pkg::AREA_W'(ACW'(quarter));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_area <= n_area;
        end
    end

    assign o_out.valid   = r_vld[TOTAL-1];
    assign o_out.area    = r_area;
    assign o_out.side_ab = r_sdly[SDLY-1].ab;
    assign o_out.side_bc = r_sdly[SDLY-1].bc;
    assign o_out.side_ac = r_sdly[SDLY-1].ac;

    // Coincident first and second vertices leave no area.
    a_zero_side_zero_area: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.side_ab == '0) |-> (o_out.area == '0))
        else $error("nonzero area with zero-length side");

    // A waiting result blocks new transactions.
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |-> !i_in.ready)
        else $error("input accepted while output stalled");

    // Reset empties the pipeline.
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid right after reset");

endmodule

>>> sv/tav_isqrt.sv
// Pipelined floor square root, one result bit per stage.
// Results advance through the stages while i_en is high; all stages hold when it is low.
module tav_isqrt #(
    parameter int IN_W = 50
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [IN_W-1:0]     i_x,
    output logic [IN_W/2-1:0]   o_root
);
    localparam int RW = IN_W / 2;

    logic [IN_W-1:0] r_rem  [RW];
    logic [RW-1:0]   r_root [RW];

    for (genvar j = 0; j < RW; j++) begin : g_stage
        localparam int B = RW - 1 - j;

        logic [IN_W-1:0] rem_in;
        logic [RW-1:0]   root_in;
        logic [IN_W:0]   trial;
        logic [IN_W-1:0] n_rem;
        logic [RW-1:0]   n_root;

        if (j == 0) begin : g_first
            assign rem_in  = i_x;
            assign root_in = '0;
        end else begin : g_next
            assign rem_in  = r_rem[j-1];
            assign root_in = r_root[j-1];
        end

        // (root + 2^B)^2 - root^2 = root * 2^(B+1) + 2^(2B).
        always_comb begin
            trial  = ((IN_W+1)'(root_in) << (B + 1)) | ((IN_W+1)'(1) << (2 * B));
            n_rem  = rem_in;
            n_root = root_in;
            if ({1'b0, rem_in} >= trial) begin
                n_rem  = IN_W'({1'b0, rem_in} - trial);
                n_root = root_in | (RW'(1) << B);
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j]  <= n_rem;
                r_root[j] <= n_root;
            end
        end
    end

    assign o_root = r_root[RW-1];

endmodule

>>> tb/triangle_area_from_vertices_core_tb.sv
`timescale 1ns / 1ps

module triangle_area_from_vertices_core_tb;

    localparam int CW        = 24;
    localparam int N_RANDOM  = 1900;
    localparam int TAIL      = 200;
    localparam int LATENCY   = 91;
    localparam int WD_LIMIT  = 5000;
    localparam int HOLD_AT   = 1500;
    localparam int HOLD_LEN  = 400;

    // One triangle: coordinates in the order ax ay az bx by bz cx cy cz.
    typedef logic [8:0][CW-1:0] t_tri;

    typedef struct packed {
        logic [tav_pkg::AREA_W-1:0] area;
        tav_pkg::t_sides            sides;
    } t_area_result;

    typedef struct {
        t_tri         tri_v;
        bit           has_exp;
        t_area_result exp_res;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    tav_in_if #(.COORD_WIDTH(CW)) in_ch ();
    tav_out_if                    out_ch ();

    triangle_area_from_vertices_core #(.COORD_WIDTH(CW)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    t_area_result pending_areas[$];
    t_row         dir_rows[$];
    int           n_errors   = 0;
    int           idle_cnt   = 0;
    int           sent_cnt   = 0;
    int           total_items = 0;
    bit           stim_done  = 0;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Floor square root, two bits per step.
    function automatic logic [127:0] floor_sqrt(input logic [127:0] x);
        logic [127:0] rem, res, one_bit, t;
        rem     = x;
        res     = '0;
        one_bit = 128'd1 << 126;
        while (one_bit != 0) begin
            t   = res + one_bit;
            res = res >> 1;
            if (rem >= t) begin
                rem = rem - t;
                res = res + one_bit;
            end
            one_bit = one_bit >> 2;
        end
        return res;
    endfunction

    // Euclidean distance between two vertices, floored.
    function automatic logic [63:0] edge_len(input logic [CW-1:0] p0, p1, p2,
                                             input logic [CW-1:0] q0, q1, q2);
        logic signed [CW+1:0] d;
        logic [CW+1:0]        m;
        logic [127:0]         acc;
        logic [CW-1:0]        ps[3];
        logic [CW-1:0]        qs[3];
        ps = '{p0, p1, p2};
        qs = '{q0, q1, q2};
        acc = '0;
        for (int k = 0; k < 3; k++) begin
            d   = $signed({{2{qs[k][CW-1]}}, qs[k]}) - $signed({{2{ps[k][CW-1]}}, ps[k]});
            m   = d[CW+1] ? -d : d;
            acc = acc + 128'(m) * 128'(m);
        end
        return 64'(floor_sqrt(acc));
    endfunction

    // Heron's formula in integer form; area saturates at the field width.
    function automatic t_area_result heron_area(input t_tri t);
        logic [63:0]  l1, l2, l3;
        logic [127:0] p, r;
        t_area_result res;
        l1 = edge_len(t[0], t[1], t[2], t[3], t[4], t[5]);
        l2 = edge_len(t[3], t[4], t[5], t[6], t[7], t[8]);
        l3 = edge_len(t[0], t[1], t[2], t[6], t[7], t[8]);
        res.area = '0;
        if (l1 <= l2 + l3 && l2 <= l1 + l3 && l3 <= l1 + l2) begin
            p = 128'(l1 + l2 + l3) * 128'(l2 + l3 - l1);
            p = p * 128'(l1 + l3 - l2);
            p = p * 128'(l1 + l2 - l3);
            r = floor_sqrt(p) >> 2;
            res.area = (r > 128'(tav_pkg::AREA_MAX)) ? tav_pkg::AREA_MAX
                                                      : r[tav_pkg::AREA_W-1:0];
        end
        res.sides.ab = (l1 > 64'(tav_pkg::SIDE_MAX)) ? tav_pkg::SIDE_MAX
                                                      : l1[tav_pkg::SIDE_W-1:0];
        res.sides.bc = (l2 > 64'(tav_pkg::SIDE_MAX)) ? tav_pkg::SIDE_MAX
                                                      : l2[tav_pkg::SIDE_W-1:0];
        res.sides.ac = (l3 > 64'(tav_pkg::SIDE_MAX)) ? tav_pkg::SIDE_MAX
                                                      : l3[tav_pkg::SIDE_W-1:0];
        return res;
    endfunction

    function automatic t_tri mk_tri(input int ax, ay, az, bx, by, bz, cx, cy, cz);
        t_tri t;
        t[0] = ax[CW-1:0]; t[1] = ay[CW-1:0]; t[2] = az[CW-1:0];
        t[3] = bx[CW-1:0]; t[4] = by[CW-1:0]; t[5] = bz[CW-1:0];
        t[6] = cx[CW-1:0]; t[7] = cy[CW-1:0]; t[8] = cz[CW-1:0];
        return t;
    endfunction

    function automatic void add_row(input t_tri t, input bit has_exp,
                                    input logic [tav_pkg::AREA_W-1:0] area,
                                    input int ab, bc, ac);
        t_row r;
        r.tri_v              = t;
        r.has_exp            = has_exp;
        r.exp_res.area       = area;
        r.exp_res.sides.ab   = ab[tav_pkg::SIDE_W-1:0];
        r.exp_res.sides.bc   = bc[tav_pkg::SIDE_W-1:0];
        r.exp_res.sides.ac   = ac[tav_pkg::SIDE_W-1:0];
        dir_rows.push_back(r);
    endfunction

    // Random triangle: full range, small local triangles, or degenerate ones.
    function automatic t_tri rand_tri();
        t_tri t;
        int   kind, k;
        int   o[3], dv[3];
        kind = $urandom_range(0, 3);
        for (int i = 0; i < 9; i++) t[i] = CW'($urandom());
        if (kind == 1) begin
            for (int i = 3; i < 9; i++)
                t[i] = t[i % 3] + CW'($urandom_range(0, 65535)) - CW'(32768);
        end else if (kind == 2) begin
            // Collinear: C = A + k*(B - A).
            k = $urandom_range(0, 3) - 1;
            for (int i = 0; i < 3; i++) begin
                o[i]      = $urandom_range(0, 1 << 20) - (1 << 19);
                dv[i]     = $urandom_range(0, 1 << 16) - (1 << 15);
                t[i]      = o[i][CW-1:0];
                t[3 + i]  = CW'(o[i] + dv[i]);
                t[6 + i]  = CW'(o[i] + k * dv[i]);
            end
        end else if (kind == 3 && $urandom_range(0, 1) == 1) begin
            // Two coincident vertices.
            for (int i = 0; i < 3; i++) t[3 + i] = t[i];
        end
        return t;
    endfunction

    // Drive one triangle and wait for the transaction.
    task automatic send_tri(input t_tri t, input bit has_exp, input t_area_result exp_res,
                            input bit allow_idle);
        int gap;
        if (allow_idle && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 16);
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.ax <= t[0]; in_ch.ay <= t[1]; in_ch.az <= t[2];
        in_ch.bx <= t[3]; in_ch.by_coord <= t[4]; in_ch.bz <= t[5];
        in_ch.cx <= t[6]; in_ch.cy <= t[7]; in_ch.cz <= t[8];
        in_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        pending_areas.push_back(has_exp ? exp_res : heron_area(t));
        sent_cnt++;
        @(negedge i_clk);
    endtask

    // Stimulus.
    initial begin
        t_area_result none;
        none = '0;
        i_rst_n = 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.ax <= '0; in_ch.ay <= '0; in_ch.az <= '0;
        in_ch.bx <= '0; in_ch.by_coord <= '0; in_ch.bz <= '0;
        in_ch.cx <= '0; in_ch.cy <= '0; in_ch.cz <= '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed rows; a 3-4-5 triangle has area exactly 6.0.
        add_row(mk_tri(0, 0, 0, 0, 0, 0, 0, 0, 0), 1, '0, 0, 0, 0);
        add_row(mk_tri(0, 0, 0, 12288, 0, 0, 0, 16384, 0), 1,
                tav_pkg::AREA_W'(6) << 24, 12288, 20480, 16384);
        add_row(mk_tri(0, 0, 0, 4096, 0, 0, 8192, 0, 0), 1, '0, 4096, 4096, 8192);
        add_row(mk_tri(-4096, 0, 0, -4096, 0, 0, 4096, 0, 0), 1, '0, 0, 8192, 8192);
        add_row(mk_tri(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607,
                       -8388608, 8388607, -8388608), 0, none, 0, 0, 0);
        add_row(mk_tri(8388607, -8388608, -8388608, -8388608, 8388607, -8388608,
                       -8388608, -8388608, 8388607), 0, none, 0, 0, 0);
        add_row(mk_tri(8388607, 8388607, 8388607, 8388607, 8388607, 8388607,
                       8388607, 8388607, 8388607), 1, '0, 0, 0, 0);
        add_row(mk_tri(-8388608, -8388608, -8388608, -8388608, -8388608, -8388608,
                       8388607, 8388607, 8388607), 0, none, 0, 0, 0);
        add_row(mk_tri(0, -12288, 0, 0, 0, -16384, -5000, 70, 3), 0, none, 0, 0, 0);
        add_row(mk_tri(1, 0, 0, 0, 1, 0, 0, 0, 1), 0, none, 0, 0, 0);
        add_row(mk_tri(-1, -1, -1, 1, 1, 1, 1, -1, 1), 0, none, 0, 0, 0);
        total_items = dir_rows.size() + N_RANDOM;
        foreach (dir_rows[i])
            send_tri(dir_rows[i].tri_v, dir_rows[i].has_exp, dir_rows[i].exp_res, 1);

        for (int i = 0; i < N_RANDOM; i++)
            send_tri(rand_tri(), 0, none, i < N_RANDOM - TAIL);
        in_ch.valid <= 1'b0;
        stim_done = 1;

        wait (pending_areas.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Receiver: random stalls, one long hold-off to fill the pipeline.
    initial begin
        int cyc;
        int gap;
        cyc = 0;
        out_ch.ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            cyc++;
            if (cyc == HOLD_AT) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_LEN) @(negedge i_clk);
                cyc += HOLD_LEN;
            end else if (sent_cnt < total_items - TAIL && $urandom_range(0, 7) == 0) begin
                gap = $urandom_range(1, 16);
                out_ch.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
                cyc += gap;
            end
            out_ch.ready <= 1'b1;
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        t_area_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_areas.size() == 0) begin
                $display("%t: unexpected result area=%0d", $realtime, out_ch.area);
                n_errors++;
            end else begin
                want = pending_areas.pop_front();
                if (out_ch.area !== want.area) begin
                    $display("%t: area expected %0d actual %0d",
                             $realtime, want.area, out_ch.area);
                    n_errors++;
                end
                if (out_ch.side_ab !== want.sides.ab) begin
                    $display("%t: side_ab expected %0d actual %0d",
                             $realtime, want.sides.ab, out_ch.side_ab);
                    n_errors++;
                end
                if (out_ch.side_bc !== want.sides.bc) begin
                    $display("%t: side_bc expected %0d actual %0d",
                             $realtime, want.sides.bc, out_ch.side_bc);
                    n_errors++;
                end
                if (out_ch.side_ac !== want.sides.ac) begin
                    $display("%t: side_ac expected %0d actual %0d",
                             $realtime, want.sides.ac, out_ch.side_ac);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cnt <= 0;
        end else begin
            idle_cnt <= idle_cnt + 1;
        end
        if (idle_cnt >= WD_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule
